### sv/keypad_hold_time_debouncer_macros.svh
// ----------------------------------------------------------------------------
// Keypad hold-time debouncer assertion macros
// Shared concurrent assertion forms, clocked on clk_i; KHTD_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_HOLD_TIME_DEBOUNCER_MACROS_SVH
`define KEYPAD_HOLD_TIME_DEBOUNCER_MACROS_SVH

// Checked only while the block is out of reset.
`define KHTD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define KHTD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/khtd_pkg.sv
// ----------------------------------------------------------------------------
// Keypad hold-time debouncer package
// Field widths, reset values and parameter defaults of the debouncer.
// ----------------------------------------------------------------------------
package khtd_pkg;

  localparam int KeyW    = 4;
  localparam int ThrW    = 8;
  localparam int HeldW   = 16;

  localparam int RowsDefault      = 4;
  localparam int ColsDefault      = 4;
  localparam int CountBitsDefault = 16;

  localparam logic [ThrW-1:0]  ThresholdReset = 8'd3;
  localparam logic [HeldW-1:0] HeldMax        = 16'hFFFF;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [ThrW-1:0]  thr_t;
  typedef logic [HeldW-1:0] held_t;

endpackage

### sv/keypad_hold_time_debouncer.sv
// ----------------------------------------------------------------------------
// Keypad hold-time debouncer
// Per-key hold counters with press, down and release reporting.
// ----------------------------------------------------------------------------
// The block accepts one key sample per clock while in_ready_o is high and
// returns one result word per sample. It is a three-stage pipeline: stage one
// registers the sample, stage two performs the read-modify-write of the key's
// hold counter and released mark, and the output stage compares against the
// threshold and forms the held frame count. A result word is offered from the
// output register once its sample has passed stage one and stage two. The
// counter is written on the edge its sample leaves stage one, so samples of the
// same key may follow back to back. A stall on the output holds each full
// stage whose successor cannot load. The threshold is taken from its register
// and must only be written while no samples are in flight.
module keypad_hold_time_debouncer #(
  parameter int ROWS       = khtd_pkg::RowsDefault,
  parameter int COLS       = khtd_pkg::ColsDefault,
  parameter int COUNT_BITS = khtd_pkg::CountBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  khtd_pkg::thr_t     cfg_hold_threshold_i,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  khtd_pkg::key_t     key_num_i,
  input  logic               level_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output khtd_pkg::key_t     result_key_o,
  output logic               is_down_o,
  output logic               is_pressed_o,
  output logic               is_released_o,
  output khtd_pkg::held_t    held_frames_o
);
  import khtd_pkg::*;

  localparam int KeyCount = ROWS * COLS;
  localparam int KeyDepth = (KeyCount < (1 << KeyW)) ? KeyCount : (1 << KeyW);
  localparam int IdxW     = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
  localparam int DiffW    = (COUNT_BITS + 1 > HeldW + 1) ? COUNT_BITS + 1 : HeldW + 1;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // Threshold register.
  thr_t thr_q;
  thr_t thr_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThresholdReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_hold_threshold_i;
    end
  end

  // A zero threshold behaves as one.
  assign thr_eff = (thr_q == '0) ? thr_t'(1) : thr_q;

  // Stage load enables, chained from the output backwards.
  logic ld1, ld2, ld3;
  logic s1_v_q, s2_v_q, out_v_q;

  assign ld3        = !out_v_q || out_ready_i;
  assign ld2        = !s2_v_q || ld3;
  assign ld1        = !s1_v_q || ld2;
  assign in_ready_o = ld1;

  // Stage one: registered sample.
  key_t s1_key_q;
  logic s1_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (ld1) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ld1) begin
      s1_key_q   <= key_num_i;
      s1_level_q <= level_i;
    end
  end

  // Stage two: counter read-modify-write. The previous sample wrote its key
  // on the edge it left stage one, so the arrays are always current here.
  cnt_t             cnt_q  [KeyDepth];
  logic [KeyDepth-1:0] mark_q;

  logic            s1_inr;
  logic [IdxW-1:0] s1_idx;
  cnt_t            cur_cnt;
  cnt_t            base_cnt;
  cnt_t            cnt_d;
  logic            mark_d;
  logic            s1_wr;

  assign s1_inr = ({{(32 - KeyW){1'b0}}, s1_key_q} < 32'(KeyCount));
  assign s1_idx = IdxW'(s1_key_q);
  assign s1_wr  = s1_v_q && ld2 && s1_inr;

  always_comb begin
    cur_cnt  = cnt_q[s1_idx];
    base_cnt = mark_q[s1_idx] ? '0 : cur_cnt;
    if (s1_level_q) begin
      cnt_d  = (base_cnt == '1) ? base_cnt : base_cnt + cnt_t'(1);
      mark_d = 1'b0;
    end else begin
      cnt_d  = base_cnt;
      mark_d = (base_cnt != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyDepth; i++) begin
        cnt_q[i] <= '0;
      end
      mark_q <= '0;
    end else if (s1_wr) begin
      cnt_q[s1_idx]  <= cnt_d;
      mark_q[s1_idx] <= mark_d;
    end
  end

  key_t s2_key_q;
  logic s2_inr_q;
  cnt_t s2_cnt_q;
  logic s2_mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (ld2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && ld2) begin
      s2_key_q  <= s1_key_q;
      s2_inr_q  <= s1_inr;
      s2_cnt_q  <= cnt_d;
      s2_mark_q <= mark_d;
    end
  end

  // Output stage: threshold compare and held frame count.
  cnt_t             thr_c;
  logic             ge_thr;
  logic             eq_thr;
  logic [DiffW-1:0] held_full;
  logic             down_d, pressed_d, released_d;
  held_t            held_d;

  always_comb begin
    thr_c      = COUNT_BITS'(thr_eff);
    ge_thr     = (s2_cnt_q >= thr_c);
    eq_thr     = (s2_cnt_q == thr_c);
    held_full  = DiffW'(s2_cnt_q) - DiffW'(thr_eff) + DiffW'(1);
    down_d     = s2_inr_q && !s2_mark_q && ge_thr;
    pressed_d  = s2_inr_q && !s2_mark_q && eq_thr;
    released_d = s2_inr_q && s2_mark_q && ge_thr;
    if (!released_d) begin
      held_d = '0;
    end else if (held_full > DiffW'(HeldMax)) begin
      held_d = HeldMax;
    end else begin
      held_d = held_full[HeldW-1:0];
    end
  end

  key_t  out_key_q;
  logic  out_down_q, out_pressed_q, out_released_q;
  held_t out_held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ld3) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && ld3) begin
      out_key_q      <= s2_key_q;
      out_down_q     <= down_d;
      out_pressed_q  <= pressed_d;
      out_released_q <= released_d;
      out_held_q     <= held_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign result_key_o  = out_key_q;
  assign is_down_o     = out_down_q;
  assign is_pressed_o  = out_pressed_q;
  assign is_released_o = out_released_q;
  assign held_frames_o = out_held_q;

  // Assertions.
  `include "keypad_hold_time_debouncer_macros.svh"

  `KHTD_ASSERT(a_mark_has_count, s2_v_q && s2_mark_q |-> s2_cnt_q != '0, "mark with zero count")
  `KHTD_ASSERT(a_press_is_down, out_v_q && out_pressed_q |-> out_down_q, "pressed word not down")
  `KHTD_ASSERT(a_release_not_down, out_v_q && out_released_q |-> !out_down_q, "down on release")
  `KHTD_ASSERT(a_held_zero, out_v_q && !out_released_q |-> out_held_q == '0, "stray held frames")
  `KHTD_ASSERT(a_held_set, out_v_q && out_released_q |-> out_held_q != '0, "zero held frames")

endmodule
